[rtl/stunbr_pkg.sv]
// ----------------------------------------------------------------------------
// stunbr_pkg
// Types and constants shared by the STUN binding responder.
// ----------------------------------------------------------------------------
package stunbr_pkg;

    localparam int HDR_LEN = 20;

    // verdict codes
    localparam logic [1:0] VERDICT_RESP     = 2'd0;
    localparam logic [1:0] VERDICT_NOT_STUN = 2'd1;
    localparam logic [1:0] VERDICT_REJECT   = 2'd2;

    // response header and attribute codes
    localparam logic [7:0] MSG_CLASS_SUCCESS = 8'h01;
    localparam logic [7:0] MSG_METHOD_BIND   = 8'h01;
    localparam logic [7:0] REQ_TYPE_BIND     = 8'h01;
    localparam logic [7:0] ATTR_XOR_MAPPED   = 8'h20;
    localparam logic [7:0] ATTR_MAPPED       = 8'h01;
    localparam logic [7:0] FAMILY_IPV4       = 8'h01;
    localparam logic [7:0] FAMILY_IPV6       = 8'h02;
    localparam logic [7:0] BODY_LEN_IPV4     = 8'd12;
    localparam logic [7:0] BODY_LEN_IPV6     = 8'd24;
    localparam logic [7:0] ATTR_LEN_IPV4     = 8'd8;
    localparam logic [7:0] ATTR_LEN_IPV6     = 8'd20;
    localparam logic [15:0] PORT_XOR_MASK    = 16'h2112;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        src_is_ipv6;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [15:0] src_port;
    } t_in_item;

    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] resp_byte;
        logic       resp_last;
    } t_out_item;

    // magic cookie, one byte per header position 4..7
    function automatic logic [7:0] cookie_byte(input logic [1:0] sel);
        logic [7:0] b;
        unique case (sel)
            2'd0:    b = 8'h21;
            2'd1:    b = 8'h12;
            2'd2:    b = 8'hA4;
            default: b = 8'h42;
        endcase
        return b;
    endfunction

endpackage

[rtl/stun_binding_responder_unit.sv]
// Timing: a rejected or non-STUN verdict appears in the cycle after the last byte
// is transferred; the first response byte appears after the fetch and load states.
// Throughput: one request byte per cycle while receiving; each response byte
// passes through a header memory read, an output register load and a transfer,
// plus any output stall, before the next byte is fetched. Input is stalled for the whole response run.
// Reset (synchronous, active low) clears control and flags; header memory is not cleared.
// ----------------------------------------------------------------------------
// stun_binding_responder_unit
// Buffers the STUN request header in a 20-byte memory and emits a binding
// success response (XOR-MAPPED or MAPPED address) or a single verdict.
// ----------------------------------------------------------------------------
module stun_binding_responder_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  stunbr_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output stunbr_pkg::t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_RECV,
        S_FETCH,
        S_LOAD,
        S_SEND
    } t_state;

    t_state                r_state;
    logic [4:0]            r_byte_count;
    logic                  r_lead_nonzero;
    logic                  r_type_bad;
    logic                  r_cookie_bad;
    logic [5:0]            r_idx;
    logic                  r_v6;
    logic                  r_xor;
    logic [127:0]          r_addr;
    logic [15:0]           r_port;
    logic [7:0]            r_rd_data;
    logic                  r_out_valid;
    stunbr_pkg::t_out_item r_out;

    logic [7:0]            r_hdr_mem [stunbr_pkg::HDR_LEN];

    logic                  in_xfer;
    logic                  store_en;
    logic [4:0]            n_byte_count;
    logic                  n_lead_nonzero;
    logic                  n_type_bad;
    logic                  n_cookie_bad;
    logic [5:0]            rd_idx;
    logic [4:0]            rd_addr;
    logic [5:0]            addr_k;
    logic [127:0]          addr_shift;
    logic [7:0]            resp_byte;
    logic                  resp_last;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign store_en = r_byte_count < 5'(stunbr_pkg::HDR_LEN);

    // header flags updated with the byte in flight
    always_comb begin
        n_byte_count   = store_en ? r_byte_count + 5'd1 : r_byte_count;
        n_lead_nonzero = r_lead_nonzero;
        n_type_bad     = r_type_bad;
        n_cookie_bad   = r_cookie_bad;
        if (r_byte_count == 5'd0) begin
            n_lead_nonzero = i_in_item.data_byte != 8'd0;
        end
        if (r_byte_count == 5'd1) begin
            n_type_bad = i_in_item.data_byte != stunbr_pkg::REQ_TYPE_BIND;
        end
        if (r_byte_count >= 5'd4 && r_byte_count <= 5'd7 &&
            i_in_item.data_byte != stunbr_pkg::cookie_byte(r_byte_count[1:0])) begin
            n_cookie_bad = 1'b1;
        end
    end

    // address byte k reads header byte 4+k for the xor mask
    always_comb begin
        addr_k  = r_idx - 6'd28;
        rd_idx  = (r_idx >= 6'd28) ? r_idx - 6'd24 : r_idx;
        rd_addr = rd_idx[4:0];
    end

    always_comb begin
        addr_shift = r_addr << {addr_k[3:0], 3'b000};
        resp_byte  = 8'd0;
        priority if (r_idx >= 6'd28) begin
            resp_byte = addr_shift[127:120] ^ (r_xor ? r_rd_data : 8'd0);
        end else if (r_idx >= 6'd4 && r_idx <= 6'd19) begin
            resp_byte = r_rd_data;
        end else begin
            unique case (r_idx[4:0])
                5'd0:    resp_byte = stunbr_pkg::MSG_CLASS_SUCCESS;
                5'd1:    resp_byte = stunbr_pkg::MSG_METHOD_BIND;
                5'd3:    resp_byte = r_v6 ? stunbr_pkg::BODY_LEN_IPV6
                                          : stunbr_pkg::BODY_LEN_IPV4;
                5'd21:   resp_byte = r_xor ? stunbr_pkg::ATTR_XOR_MAPPED
                                           : stunbr_pkg::ATTR_MAPPED;
                5'd23:   resp_byte = r_v6 ? stunbr_pkg::ATTR_LEN_IPV6
                                          : stunbr_pkg::ATTR_LEN_IPV4;
                5'd25:   resp_byte = r_v6 ? stunbr_pkg::FAMILY_IPV6
                                          : stunbr_pkg::FAMILY_IPV4;
                5'd26:   resp_byte = r_port[15:8];
                5'd27:   resp_byte = r_port[7:0];
                default: resp_byte = 8'd0;
            endcase
        end
        resp_last = r_idx == (r_v6 ? 6'd43 : 6'd31);
    end

    // header memory: written only while receiving, read only in fetch
    always_ff @(posedge i_clk) begin
        if (in_xfer && store_en) begin
            r_hdr_mem[r_byte_count] <= i_in_item.data_byte;
        end
        if (r_state == S_FETCH) begin
            r_rd_data <= r_hdr_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_RECV;
            r_byte_count   <= 5'd0;
            r_lead_nonzero <= 1'b0;
            r_type_bad     <= 1'b0;
            r_cookie_bad   <= 1'b0;
            r_idx          <= 6'd0;
            r_out_valid    <= 1'b0;
        end else begin
            unique case (r_state)
                S_RECV: begin
                    if (in_xfer) begin
                        if (i_in_item.last_byte) begin
                            r_byte_count   <= 5'd0;
                            r_lead_nonzero <= 1'b0;
                            r_type_bad     <= 1'b0;
                            r_cookie_bad   <= 1'b0;
                            r_idx          <= 6'd0;
                            r_v6           <= i_in_item.src_is_ipv6;
                            r_xor          <= !n_cookie_bad;
                            r_port         <= n_cookie_bad ? i_in_item.src_port
                                : i_in_item.src_port ^ stunbr_pkg::PORT_XOR_MASK;
                            r_addr         <= i_in_item.src_is_ipv6
                                ? {i_in_item.src_addr_hi, i_in_item.src_addr_lo}
                                : {i_in_item.src_addr_lo[31:0], 96'd0};
                            priority if (n_lead_nonzero) begin
                                r_out       <= '{stunbr_pkg::VERDICT_NOT_STUN, 8'd0, 1'b1};
                                r_out_valid <= 1'b1;
                                r_state     <= S_SEND;
                            end else if (n_byte_count < 5'(stunbr_pkg::HDR_LEN) ||
                                         n_type_bad) begin
                                r_out       <= '{stunbr_pkg::VERDICT_REJECT, 8'd0, 1'b1};
                                r_out_valid <= 1'b1;
                                r_state     <= S_SEND;
                            end else begin
                                r_state <= S_FETCH;
                            end
                        end else begin
                            r_byte_count   <= n_byte_count;
                            r_lead_nonzero <= n_lead_nonzero;
                            r_type_bad     <= n_type_bad;
                            r_cookie_bad   <= n_cookie_bad;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_out       <= '{stunbr_pkg::VERDICT_RESP, resp_byte, resp_last};
                    r_out_valid <= 1'b1;
                    r_state     <= S_SEND;
                end
                S_SEND: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out.resp_last) begin
                            r_state <= S_RECV;
                        end else begin
                            r_idx   <= r_idx + 6'd1;
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: r_state <= S_RECV;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_RECV;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("output pending while input open");

    a_verdict_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.verdict != stunbr_pkg::VERDICT_RESP
        |-> o_out_item.resp_last && o_out_item.resp_byte == 8'd0)
        else $error("verdict transfer not a single zero byte");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_item.last_byte |=> o_in_stall && r_byte_count == 5'd0)
        else $error("packet state not cleared after last byte");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= 5'(stunbr_pkg::HDR_LEN))
        else $error("byte count past header length");

    a_resp_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_RECV |-> r_idx <= 6'd43)
        else $error("response index overrun");

endmodule
